@@ design/dtr_pkg.sv @@
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared types and constants for the domain-to-texture rectangle core.
// ----------------------------------------------------------------------------
package dtr_pkg;

    localparam int MAX_RANK   = 4;
    localparam int INDEX_BITS = 32;
    localparam int DIM_BITS   = 16;
    localparam int RANK_BITS  = $clog2(MAX_RANK + 1);
    localparam int CNT_BITS   = $clog2(INDEX_BITS);

    localparam int MUL_STEPS  = DIM_BITS;
    localparam int DIV_STEPS  = INDEX_BITS;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 120;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } dtr_op_t;

    typedef struct packed {
        logic                  start;
        dtr_op_t               op;
        logic [INDEX_BITS-1:0] a;
        logic [DIM_BITS-1:0]   b;
        logic [INDEX_BITS-1:0] c;
    } dtr_cmd_t;

    typedef struct packed {
        logic                  done;
        logic [INDEX_BITS-1:0] value;
        logic [DIM_BITS-1:0]   rem;
    } dtr_res_t;

endpackage

@@ design/dtr_iter_unit.sv @@
// ----------------------------------------------------------------------------
// dtr_iter_unit
// Shared iterative unit: shift-add multiply-accumulate and restoring divide.
// ----------------------------------------------------------------------------
module dtr_iter_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  dtr_pkg::dtr_cmd_t cmd,
    output dtr_pkg::dtr_res_t res
);
    import dtr_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    dtr_op_t               op_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [INDEX_BITS-1:0] acc_reg;
    logic [INDEX_BITS-1:0] opa_reg;
    logic [DIM_BITS-1:0]   opb_reg;
    logic [DIM_BITS-1:0]   rem_reg;

    logic [DIM_BITS+1:0]   diff;
    logic                  q_bit;
    logic [INDEX_BITS-1:0] acc_next;
    logic [DIM_BITS-1:0]   rem_next;

    always_comb begin
        diff  = {1'b0, rem_reg, acc_reg[INDEX_BITS-1]} - {2'b00, opb_reg};
        q_bit = ~diff[DIM_BITS+1];
        if (op_reg == OP_MUL) begin
            acc_next = opb_reg[0] ? (acc_reg + opa_reg) : acc_reg;
            rem_next = rem_reg;
        end else begin
            acc_next = {acc_reg[INDEX_BITS-2:0], q_bit};
            rem_next = q_bit ? diff[DIM_BITS-1:0]
                             : {rem_reg[DIM_BITS-2:0], acc_reg[INDEX_BITS-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !cmd.start && busy_reg && (cnt_reg == '0);
            if (cmd.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= cmd.op;
            opa_reg <= cmd.a;
            opb_reg <= cmd.b;
            rem_reg <= '0;
            if (cmd.op == OP_MUL) begin
                cnt_reg <= CNT_BITS'(MUL_STEPS - 1);
                acc_reg <= cmd.c;
            end else begin
                cnt_reg <= CNT_BITS'(DIV_STEPS - 1);
                acc_reg <= cmd.a;
            end
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            opa_reg <= {opa_reg[INDEX_BITS-2:0], 1'b0};
            if (op_reg == OP_MUL) begin
                opb_reg <= {1'b0, opb_reg[DIM_BITS-1:1]};
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign res.done  = done_reg;
    assign res.value = acc_reg;
    assign res.rem   = rem_reg;

endmodule

@@ design/dtr_ctrl.sv @@
// ----------------------------------------------------------------------------
// dtr_ctrl
// Sequencer, domain state and output register of the rectangle core.
// ----------------------------------------------------------------------------
module dtr_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dtr_pkg::DIM_BITS-1:0]    cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dtr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dtr_pkg::M_TDATA_W-1:0]   m_tdata,
    output dtr_pkg::dtr_cmd_t               cmd,
    input  dtr_pkg::dtr_res_t               res
);
    import dtr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_MUL_FIRST = 6'b000010,
        ST_MUL_LAST  = 6'b000100,
        ST_DIV_FIRST = 6'b001000,
        ST_DIV_LAST  = 6'b010000,
        ST_EMIT      = 6'b100000
    } state_t;

    state_t                state_reg;
    logic                  launch_reg;
    logic                  launch_next;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [DIM_BITS-1:0]   width_reg;

    logic [INDEX_BITS-1:0] first_reg;
    logic [INDEX_BITS-1:0] last_reg;
    logic                  whole_reg;
    logic [DIM_BITS-1:0]   prev_min_reg;
    logic [DIM_BITS-1:0]   prev_max_reg;
    logic [DIM_BITS-1:0]   cur_min_reg;
    logic [DIM_BITS-1:0]   cur_max_reg;
    logic [RANK_BITS-1:0]  dims_reg;

    logic [DIM_BITS-1:0]   dmin_reg;
    logic [DIM_BITS-1:0]   dmax_reg;
    logic [DIM_BITS-1:0]   ext_reg;
    logic                  tlast_reg;
    logic                  xlate_reg;

    logic [INDEX_BITS-1:0] q_first_reg;
    logic [DIM_BITS-1:0]   r_first_reg;
    logic [INDEX_BITS-1:0] q_last_reg;
    logic [DIM_BITS-1:0]   r_last_reg;

    logic [DIM_BITS-1:0]   in_min;
    logic [DIM_BITS-1:0]   in_max;
    logic [DIM_BITS-1:0]   in_ext;
    logic                  span_ok;
    logic [DIM_BITS-1:0]   width_eff;

    logic [DIM_BITS-1:0]   o_min_x;
    logic [31:0]           o_min_y;
    logic [DIM_BITS-1:0]   o_max_x;
    logic [32:0]           o_max_y;
    logic [DIM_BITS-1:0]   o_base;

    assign in_min    = s_tdata[15:0];
    assign in_max    = s_tdata[31:16];
    assign in_ext    = s_tdata[47:32];
    assign span_ok   = (in_max >= in_min) && ((in_max - in_min) == in_ext);
    assign width_eff = (width_reg == '0) ? DIM_BITS'(1) : width_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        cmd.start = launch_reg;
        cmd.op    = OP_MUL;
        cmd.a     = first_reg;
        cmd.b     = ext_reg;
        cmd.c     = INDEX_BITS'(dmin_reg);
        case (state_reg)
            ST_MUL_LAST: begin
                cmd.a = last_reg;
                cmd.c = INDEX_BITS'(dmax_reg) - 1'b1;
            end
            ST_DIV_FIRST: begin
                cmd.op = OP_DIV;
                cmd.b  = width_eff;
            end
            ST_DIV_LAST: begin
                cmd.op = OP_DIV;
                cmd.a  = last_reg;
                cmd.b  = width_eff;
            end
            default: begin
                cmd.op = OP_MUL;
            end
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_IDLE: begin
                launch_next = s_tvalid &&
                              ((dims_reg < RANK_BITS'(MAX_RANK)) || (s_tlast && s_tuser));
            end
            ST_MUL_FIRST: begin
                launch_next = res.done;
            end
            ST_MUL_LAST: begin
                launch_next = res.done && tlast_reg && xlate_reg;
            end
            ST_DIV_FIRST: begin
                launch_next = res.done;
            end
            default: begin
                launch_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (xlate_reg) begin
            o_base  = r_first_reg;
            o_min_y = q_first_reg;
            o_max_y = {1'b0, q_last_reg} + 1'b1;
            if (q_first_reg != q_last_reg) begin
                o_min_x = '0;
                o_max_x = width_eff;
            end else begin
                o_min_x = r_first_reg;
                o_max_x = r_last_reg + 1'b1;
            end
        end else begin
            o_base  = '0;
            o_min_x = cur_min_reg;
            o_max_x = cur_max_reg;
            o_min_y = 32'(prev_min_reg);
            o_max_y = 33'(prev_max_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launch_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            width_reg    <= DIM_BITS'(1);
            first_reg    <= '0;
            last_reg     <= '0;
            whole_reg    <= 1'b1;
            prev_min_reg <= '0;
            prev_max_reg <= DIM_BITS'(1);
            cur_min_reg  <= '0;
            cur_max_reg  <= DIM_BITS'(1);
            dims_reg     <= '0;
        end else begin
            launch_reg <= launch_next;
            if (cfg_we) begin
                width_reg <= cfg_wdata;
            end
            if (state_reg == ST_EMIT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (dims_reg < RANK_BITS'(MAX_RANK)) begin
                            whole_reg   <= whole_reg & span_ok;
                            cur_min_reg <= in_min;
                            cur_max_reg <= in_max;
                            if (dims_reg == '0) begin
                                prev_min_reg <= '0;
                                prev_max_reg <= DIM_BITS'(1);
                            end else begin
                                prev_min_reg <= cur_min_reg;
                                prev_max_reg <= cur_max_reg;
                            end
                            dims_reg  <= dims_reg + 1'b1;
                            state_reg <= ST_MUL_FIRST;
                        end else if (s_tlast) begin
                            if (s_tuser) begin
                                state_reg <= ST_DIV_FIRST;
                            end else begin
                                state_reg <= ST_EMIT;
                            end
                        end
                    end
                end
                ST_MUL_FIRST: begin
                    if (res.done) begin
                        first_reg <= res.value;
                        state_reg <= ST_MUL_LAST;
                    end
                end
                ST_MUL_LAST: begin
                    if (res.done) begin
                        last_reg <= res.value;
                        if (!tlast_reg) begin
                            state_reg <= ST_IDLE;
                        end else if (xlate_reg) begin
                            state_reg <= ST_DIV_FIRST;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_DIV_FIRST: begin
                    if (res.done) begin
                        q_first_reg <= res.value;
                        r_first_reg <= res.rem;
                        state_reg   <= ST_DIV_LAST;
                    end
                end
                ST_DIV_LAST: begin
                    if (res.done) begin
                        q_last_reg <= res.value;
                        r_last_reg <= res.rem;
                        state_reg  <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        first_reg    <= '0;
                        last_reg     <= '0;
                        whole_reg    <= 1'b1;
                        prev_min_reg <= '0;
                        prev_max_reg <= DIM_BITS'(1);
                        cur_min_reg  <= '0;
                        cur_max_reg  <= DIM_BITS'(1);
                        dims_reg     <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            dmin_reg  <= in_min;
            dmax_reg  <= in_max;
            ext_reg   <= in_ext;
            tlast_reg <= s_tlast;
            xlate_reg <= s_tuser;
        end
        if (state_reg == ST_EMIT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {6'b000000, whole_reg, o_base, o_max_y, o_max_x, o_min_y, o_min_x};
        end
    end

endmodule

@@ design/domain_to_texture_rect_core.sv @@
// ----------------------------------------------------------------------------
// domain_to_texture_rect_core
// Folds a copy domain into a texture rectangle, one dimension per transaction.
// ----------------------------------------------------------------------------
// The input channel carries one dimension per transaction, outermost first:
// s_tdata holds dim_min, dim_max and dim_extent, s_tlast marks the innermost
// dimension and s_tuser requests linear address translation on that item.
// Each of the first four dimensions runs two Horner steps on a shared
// shift-add unit, 16 steps each, and the next dimension is accepted
// once both are done. Further dimensions are accepted without arithmetic.
// Without translation the result transaction follows the multiplications
// of the last dimension. With translation, two 32-step divisions by the
// texture width follow on the same unit before the result. The unit is
// the only arithmetic resource, and s_tready stays low while it works.
// The user writes configuration (cfg_we, cfg_wdata) only while idle; unenforced.
// A synchronous low aresetn restores texture width 1 and an empty domain.
// The result waits in an output register; a stalled receiver only holds up
// the block when the next result is ready to be loaded.
// ----------------------------------------------------------------------------
module domain_to_texture_rect_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dtr_pkg::DIM_BITS-1:0]    cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // dim_min[15:0], dim_max[31:16], dim_extent[47:32]
    input  logic [dtr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    // translate_address[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // rect_min_x[15:0], rect_min_y[47:16], rect_max_x[63:48], rect_max_y[96:64],
    // base_offset[112:97], covers_whole_stream[113], zero padding[119:114]
    output logic [dtr_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dtr_pkg::*;

    dtr_cmd_t cmd;
    dtr_res_t res;

    dtr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .res       (res)
    );

    dtr_iter_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .res     (res)
    );

endmodule

@@ design/dtr_checker.sv @@
// ----------------------------------------------------------------------------
// dtr_checker
// Port-level checks for the domain-to-texture rectangle core.
// ----------------------------------------------------------------------------
module dtr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dtr_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dtr_pkg::*;

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid not cleared by reset.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result transaction changed.");

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("Input accepted right after the last dimension.");

    a_padding_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:114] == '0)
        else $error("Result padding bits are not zero.");

endmodule

bind domain_to_texture_rect_core dtr_checker u_dtr_checker (.*);
